/* hw/rtl/tida_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the transaction ID allocator.
package tida_pkg;

    localparam int ACT_W = 3;
    localparam int ST_W  = 3;
    localparam int TAG_W = 16;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_USED = 3'd2;
    localparam logic [ST_W-1:0] ST_TIMEOUT  = 3'd3;
    localparam logic [ST_W-1:0] ST_SWEPT    = 3'd4;

    // Commands broadcast from the controller to every cell
    typedef struct packed {
        logic inject;      // place the token at cell 0
        logic step;        // token cell applies its scan op, token moves on
        logic scan_alloc;  // scan op: 1 allocate, 0 tick
        logic dir_set;     // addressed cell takes new tags
        logic dir_rel;     // addressed cell is freed
    } ctl_t;

    // Per-cell status seen by the controller
    typedef struct packed {
        logic tok;
        logic in_use;
        logic aged;
    } cell_stat_t;

endpackage

/* hw/rtl/transaction_id_allocator_timeout_core.sv */
`timescale 1ns / 1ps
// Transaction ID allocator with two-tick timeout: controller and row of entry cells.
//
// Holds NUM_IDS transaction IDs (1..NUM_IDS), one per cell in a row. Set, query
// and release address one cell directly and unknown actions return not-used; the
// request passes the execute and finish states and its result is registered as it
// leaves finish. Allocate and tick pass a token along the cell row, one cell per
// cycle unless a tick must hold it while a timeout report waits for the output
// register: allocate stops at the lowest free slot (or at the last cell when the
// table is full), a tick walks the whole row. An output stall while a result waits
// in the output register also holds the finish state. One request is in progress at
// a time; in_stall is high until its final result is registered. A tick gives one
// timeout report per expired ID in ID order, or a single sweep done result, and last
// marks the final result of every request.
module transaction_id_allocator_timeout_core #(
    parameter int  NUM_IDS = 16,
    localparam int IDX_W   = $clog2(NUM_IDS),
    localparam int ID_W    = $clog2(NUM_IDS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tida_pkg::ACT_W-1:0]   action,
    input  logic [ID_W-1:0]              txn_id,
    input  logic [tida_pkg::TAG_W-1:0]   subject_in,
    input  logic [tida_pkg::TAG_W-1:0]   requester_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tida_pkg::ST_W-1:0]    status,
    output logic [ID_W-1:0]              result_id,
    output logic [tida_pkg::TAG_W-1:0]   subject_out,
    output logic [tida_pkg::TAG_W-1:0]   requester_out,
    output logic                         last
);
    import tida_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [ACT_W-1:0] act_reg;
    logic [ACT_W-1:0] act_next;
    logic [ID_W-1:0]  id_reg;
    logic [ID_W-1:0]  id_next;
    logic [TAG_W-1:0] subj_reg;
    logic [TAG_W-1:0] subj_next;
    logic [TAG_W-1:0] req_reg;
    logic [TAG_W-1:0] req_next;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] scan_idx_next;

    // held result, so the final report of a tick can carry last
    logic             pend_v_reg;
    logic             pend_v_next;
    logic [ST_W-1:0]  pend_st_reg;
    logic [ST_W-1:0]  pend_st_next;
    logic [ID_W-1:0]  pend_id_reg;
    logic [ID_W-1:0]  pend_id_next;
    logic [TAG_W-1:0] pend_subj_reg;
    logic [TAG_W-1:0] pend_subj_next;
    logic [TAG_W-1:0] pend_req_reg;
    logic [TAG_W-1:0] pend_req_next;

    logic             out_v_reg;
    logic             out_v_next;
    logic [ST_W-1:0]  out_st_reg;
    logic [ST_W-1:0]  out_st_next;
    logic [ID_W-1:0]  out_id_reg;
    logic [ID_W-1:0]  out_id_next;
    logic [TAG_W-1:0] out_subj_reg;
    logic [TAG_W-1:0] out_subj_next;
    logic [TAG_W-1:0] out_req_reg;
    logic [TAG_W-1:0] out_req_next;
    logic             out_last_reg;
    logic             out_last_next;

    ctl_t             ctl;
    cell_stat_t       stat [NUM_IDS];
    logic [TAG_W-1:0] cell_subj [NUM_IDS];
    logic [TAG_W-1:0] cell_req [NUM_IDS];
    logic [NUM_IDS-1:0] tok_chain;
    logic [NUM_IDS-1:0] tok_vec;
    logic [NUM_IDS-1:0] in_use_vec;
    logic [NUM_IDS-1:0] aged_vec;

    logic [IDX_W-1:0] slot;
    logic             id_ok;
    logic             hit;
    logic             tok_free;
    logic             tok_exp;
    logic [TAG_W-1:0] tok_subj;
    logic [TAG_W-1:0] tok_req;
    logic             out_free;
    logic             is_last;
    logic [ID_W-1:0]  scan_id;

    assign tok_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < NUM_IDS; g++)
        begin : g_cell
            tida_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .dir_idx  (slot),
                .set_subj (subj_reg),
                .set_req  (req_reg),
                .tok_in   (tok_chain[g]),
                .stat     (stat[g]),
                .subj     (cell_subj[g]),
                .req      (cell_req[g])
            );
            if (g < NUM_IDS - 1)
            begin : g_link
                assign tok_chain[g+1] = stat[g].tok;
            end
            assign tok_vec[g]     = stat[g].tok;
            assign in_use_vec[g]  = stat[g].in_use;
            assign aged_vec[g]    = stat[g].aged;
        end
    endgenerate

    assign slot  = IDX_W'(id_reg - ID_W'(1));
    assign id_ok = (id_reg != '0) && (id_reg <= ID_W'(NUM_IDS));
    assign hit   = id_ok && in_use_vec[slot];

    // at most one cell holds the token, so an OR picks its entry
    always_comb
    begin
        tok_free = 1'b0;
        tok_exp  = 1'b0;
        tok_subj = '0;
        tok_req  = '0;
        for (int i = 0; i < NUM_IDS; i++)
        begin
            if (stat[i].tok)
            begin
                tok_free = tok_free | !stat[i].in_use;
                tok_exp  = tok_exp | (stat[i].in_use && stat[i].aged);
                tok_subj = tok_subj | cell_subj[i];
                tok_req  = tok_req | cell_req[i];
            end
        end
    end

    assign out_free = !out_v_reg || !out_stall;
    assign is_last  = (scan_idx_reg == IDX_W'(NUM_IDS - 1));
    assign scan_id  = ID_W'(scan_idx_reg) + ID_W'(1);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        id_next        = id_reg;
        subj_next      = subj_reg;
        req_next       = req_reg;
        scan_idx_next  = scan_idx_reg;
        pend_v_next    = pend_v_reg;
        pend_st_next   = pend_st_reg;
        pend_id_next   = pend_id_reg;
        pend_subj_next = pend_subj_reg;
        pend_req_next  = pend_req_reg;
        out_v_next     = out_v_reg;
        out_st_next    = out_st_reg;
        out_id_next    = out_id_reg;
        out_subj_next  = out_subj_reg;
        out_req_next   = out_req_reg;
        out_last_next  = out_last_reg;
        ctl            = '0;
        ctl.scan_alloc = (act_reg == ACT_ALLOC);

        if (out_v_reg && !out_stall)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    id_next    = txn_id;
                    subj_next  = subject_in;
                    req_next   = requester_in;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                scan_idx_next  = '0;
                pend_v_next    = 1'b1;
                pend_st_next   = ST_NOT_USED;
                pend_id_next   = '0;
                pend_subj_next = '0;
                pend_req_next  = '0;
                state_next     = S_FIN;
                case (act_reg)
                    ACT_ALLOC, ACT_TICK:
                    begin
                        ctl.inject  = 1'b1;
                        pend_v_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                    ACT_SET:
                    begin
                        if (hit)
                        begin
                            ctl.dir_set  = 1'b1;
                            pend_st_next = ST_OK;
                        end
                    end
                    ACT_QUERY:
                    begin
                        if (hit)
                        begin
                            pend_st_next   = ST_OK;
                            pend_subj_next = cell_subj[slot];
                            pend_req_next  = cell_req[slot];
                        end
                    end
                    ACT_RELEASE:
                    begin
                        if (hit)
                        begin
                            ctl.dir_rel  = 1'b1;
                            pend_st_next = ST_OK;
                        end
                    end
                    default:
                    begin
                        pend_st_next = ST_NOT_USED;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (ctl.scan_alloc)
                begin
                    ctl.step      = 1'b1;
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    if (tok_free)
                    begin
                        pend_v_next    = 1'b1;
                        pend_st_next   = ST_OK;
                        pend_id_next   = scan_id;
                        pend_subj_next = '0;
                        pend_req_next  = '0;
                        state_next     = S_FIN;
                    end
                    else if (is_last)
                    begin
                        pend_v_next    = 1'b1;
                        pend_st_next   = ST_FULL;
                        pend_id_next   = '0;
                        pend_subj_next = '0;
                        pend_req_next  = '0;
                        state_next     = S_FIN;
                    end
                end
                else if (!(tok_exp && pend_v_reg && !out_free))
                begin
                    ctl.step      = 1'b1;
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    if (tok_exp)
                    begin
                        // earlier report is now known not to be the final one
                        if (pend_v_reg)
                        begin
                            out_v_next    = 1'b1;
                            out_st_next   = pend_st_reg;
                            out_id_next   = pend_id_reg;
                            out_subj_next = pend_subj_reg;
                            out_req_next  = pend_req_reg;
                            out_last_next = 1'b0;
                        end
                        pend_v_next    = 1'b1;
                        pend_st_next   = ST_TIMEOUT;
                        pend_id_next   = scan_id;
                        pend_subj_next = tok_subj;
                        pend_req_next  = tok_req;
                    end
                    if (is_last)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_v_next    = 1'b1;
                    out_last_next = 1'b1;
                    if (pend_v_reg)
                    begin
                        out_st_next   = pend_st_reg;
                        out_id_next   = pend_id_reg;
                        out_subj_next = pend_subj_reg;
                        out_req_next  = pend_req_reg;
                    end
                    else
                    begin
                        out_st_next   = ST_SWEPT;
                        out_id_next   = '0;
                        out_subj_next = '0;
                        out_req_next  = '0;
                    end
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            pend_v_reg   <= pend_v_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        id_reg        <= id_next;
        subj_reg      <= subj_next;
        req_reg       <= req_next;
        pend_st_reg   <= pend_st_next;
        pend_id_reg   <= pend_id_next;
        pend_subj_reg <= pend_subj_next;
        pend_req_reg  <= pend_req_next;
        out_st_reg    <= out_st_next;
        out_id_reg    <= out_id_next;
        out_subj_reg  <= out_subj_next;
        out_req_reg   <= out_req_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_v_reg;
    assign status        = out_st_reg;
    assign result_id     = out_id_reg;
    assign subject_out   = out_subj_reg;
    assign requester_out = out_req_reg;
    assign last          = out_last_reg;

    a_tok_single: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> $onehot(tok_vec))
        else $error("scan token lost or duplicated");

    a_tok_at_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> tok_vec[scan_idx_reg])
        else $error("scan index out of step with token");

    a_aged_live: assert property (@(posedge clk) disable iff (!rst_n)
        (aged_vec & ~in_use_vec) == '0)
        else $error("aged flag on a free entry");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_EXEC)
        else $error("accepted request not executed");

endmodule

/* hw/rtl/tida_cell.sv */
`timescale 1ns / 1ps
// One table entry: live and aged flags, two tags and a stage of the scan token chain.
module tida_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tida_pkg::ctl_t           ctl,
    input  logic [IDX_W-1:0]         dir_idx,
    input  logic [tida_pkg::TAG_W-1:0] set_subj,
    input  logic [tida_pkg::TAG_W-1:0] set_req,
    input  logic                     tok_in,
    output tida_pkg::cell_stat_t     stat,
    output logic [tida_pkg::TAG_W-1:0] subj,
    output logic [tida_pkg::TAG_W-1:0] req
);
    import tida_pkg::*;

    logic             tok_reg;
    logic             tok_next;
    logic             in_use_reg;
    logic             in_use_next;
    logic             aged_reg;
    logic             aged_next;
    logic [TAG_W-1:0] subj_reg;
    logic [TAG_W-1:0] req_reg;
    logic             act;
    logic             sel;
    logic             take;

    assign act  = ctl.step && tok_reg;
    assign sel  = (dir_idx == IDX_W'(CELL_IDX));
    assign take = act && ctl.scan_alloc && !in_use_reg;

    always_comb
    begin
        tok_next    = tok_reg;
        in_use_next = in_use_reg;
        aged_next   = aged_reg;
        if (ctl.inject)
        begin
            tok_next = (CELL_IDX == 0);
        end
        else if (ctl.step)
        begin
            tok_next = tok_in;
        end
        if (take)
        begin
            in_use_next = 1'b1;
            aged_next   = 1'b0;
        end
        else if (act && !ctl.scan_alloc && in_use_reg)
        begin
            // second tick expires the entry, first one only marks it
            if (aged_reg)
            begin
                in_use_next = 1'b0;
                aged_next   = 1'b0;
            end
            else
            begin
                aged_next = 1'b1;
            end
        end
        else if (ctl.dir_rel && sel)
        begin
            in_use_next = 1'b0;
            aged_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= 1'b0;
            in_use_reg <= 1'b0;
            aged_reg   <= 1'b0;
        end
        else
        begin
            tok_reg    <= tok_next;
            in_use_reg <= in_use_next;
            aged_reg   <= aged_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            subj_reg <= '0;
            req_reg  <= '0;
        end
        else if (ctl.dir_set && sel)
        begin
            subj_reg <= set_subj;
            req_reg  <= set_req;
        end
    end

    assign stat.tok    = tok_reg;
    assign stat.in_use = in_use_reg;
    assign stat.aged   = aged_reg;
    assign subj        = subj_reg;
    assign req         = req_reg;

endmodule

/* sim/transaction_id_allocator_timeout_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the transaction ID allocator with two-tick timeout.
module transaction_id_allocator_timeout_core_tb;

    import tida_pkg::*;

    localparam int NUM_IDS = 16;
    localparam int ID_W    = $clog2(NUM_IDS + 1);

    localparam logic [ACT_W-1:0] ACT_BAD_CODE = 3'd7;
    localparam logic [ID_W-1:0]  ID_ALL_ONES  = '1;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] subj;
        logic [TAG_W-1:0] req;
        logic             last;
    } reply_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  txn_id;
    logic [TAG_W-1:0] subject_in;
    logic [TAG_W-1:0] requester_in;
    logic             out_valid;
    logic             out_stall;
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  result_id;
    logic [TAG_W-1:0] subject_out;
    logic [TAG_W-1:0] requester_out;
    logic             last;

    // Predicted table contents
    bit               live [NUM_IDS];
    bit               stale [NUM_IDS];
    logic [TAG_W-1:0] subj_tag [NUM_IDS];
    logic [TAG_W-1:0] req_tag [NUM_IDS];

    reply_t replies_due[$];
    reply_t head_reply;
    int     mismatches;
    bit     idle_on;
    int     stall_left;

    transaction_id_allocator_timeout_core #(
        .NUM_IDS(NUM_IDS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .txn_id       (txn_id),
        .subject_in   (subject_in),
        .requester_in (requester_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_id    (result_id),
        .subject_out  (subject_out),
        .requester_out(requester_out),
        .last         (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
            $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic push_reply(input logic [ST_W-1:0] st, input logic [ID_W-1:0] id,
                              input logic [TAG_W-1:0] subj, input logic [TAG_W-1:0] req,
                              input logic lst);
        reply_t r;
        r.status = st;
        r.id     = id;
        r.subj   = subj;
        r.req    = req;
        r.last   = lst;
        replies_due.push_back(r);
    endtask

    // Applies one accepted request to the predicted table and queues its replies
    task automatic predict_table_op(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                                    input logic [TAG_W-1:0] subj,
                                    input logic [TAG_W-1:0] req);
        int     slot;
        int     found;
        int     expired;
        bit     hit;
        reply_t r;
        hit  = (id >= 1) && (id <= NUM_IDS);
        slot = hit ? int'(id) - 1 : 0;
        hit  = hit && live[slot];
        case (act)
            ACT_ALLOC:
            begin
                found = -1;
                for (int i = 0; i < NUM_IDS; i++)
                    if (!live[i] && found < 0)
                        found = i;
                if (found < 0)
                    push_reply(ST_FULL, '0, '0, '0, 1'b1);
                else
                begin
                    live[found]     = 1'b1;
                    stale[found]    = 1'b0;
                    subj_tag[found] = '0;
                    req_tag[found]  = '0;
                    push_reply(ST_OK, ID_W'(found + 1), '0, '0, 1'b1);
                end
            end
            ACT_SET:
            begin
                if (hit)
                begin
                    subj_tag[slot] = subj;
                    req_tag[slot]  = req;
                    push_reply(ST_OK, '0, '0, '0, 1'b1);
                end
                else
                    push_reply(ST_NOT_USED, '0, '0, '0, 1'b1);
            end
            ACT_QUERY:
            begin
                if (hit)
                    push_reply(ST_OK, '0, subj_tag[slot], req_tag[slot], 1'b1);
                else
                    push_reply(ST_NOT_USED, '0, '0, '0, 1'b1);
            end
            ACT_RELEASE:
            begin
                if (hit)
                begin
                    live[slot]  = 1'b0;
                    stale[slot] = 1'b0;
                    push_reply(ST_OK, '0, '0, '0, 1'b1);
                end
                else
                    push_reply(ST_NOT_USED, '0, '0, '0, 1'b1);
            end
            ACT_TICK:
            begin
                expired = 0;
                for (int i = 0; i < NUM_IDS; i++)
                begin
                    if (live[i])
                    begin
                        if (stale[i])
                        begin
                            push_reply(ST_TIMEOUT, ID_W'(i + 1), subj_tag[i], req_tag[i], 1'b0);
                            live[i]  = 1'b0;
                            stale[i] = 1'b0;
                            expired++;
                        end
                        else
                            stale[i] = 1'b1;
                    end
                end
                if (expired == 0)
                    push_reply(ST_SWEPT, '0, '0, '0, 1'b1);
                else
                begin
                    r = replies_due.pop_back();
                    r.last = 1'b1;
                    replies_due.push_back(r);
                end
            end
            default:
                push_reply(ST_NOT_USED, '0, '0, '0, 1'b1);
        endcase
    endtask

    task automatic send_req(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                            input logic [TAG_W-1:0] subj, input logic [TAG_W-1:0] req);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        txn_id       <= id;
        subject_in   <= subj;
        requester_in <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_table_op(act, id, subj, req);
    endtask

    // Mostly a live ID, now and then anything the field can hold
    function automatic logic [ID_W-1:0] pick_txn_id();
        int cands[$];
        for (int i = 0; i < NUM_IDS; i++)
            if (live[i])
                cands.push_back(i + 1);
        if (cands.size() > 0 && $urandom_range(0, 9) < 8)
            return ID_W'(cands[$urandom_range(0, cands.size() - 1)]);
        return ID_W'($urandom_range(0, int'(ID_ALL_ONES)));
    endfunction

    task automatic test_full_table();
        for (int i = 0; i <= NUM_IDS; i++)
            send_req(ACT_ALLOC, ID_W'($urandom), TAG_W'($urandom), TAG_W'($urandom));
    endtask

    task automatic test_tag_extremes();
        send_req(ACT_SET, ID_W'(NUM_IDS), '1, '1);
        send_req(ACT_QUERY, ID_W'(NUM_IDS), '0, '0);
    endtask

    task automatic test_bad_ids();
        send_req(ACT_SET, '0, '1, '1);
        send_req(ACT_QUERY, ID_ALL_ONES, '0, '0);
        send_req(ACT_RELEASE, ID_W'(NUM_IDS + 1), '0, '0);
        send_req(ACT_BAD_CODE, ID_W'(1), '1, '1);
    endtask

    // First tick only marks, second expires the whole table
    task automatic test_two_tick_expiry();
        send_req(ACT_TICK, '0, '0, '0);
        send_req(ACT_TICK, '0, '0, '0);
    endtask

    task automatic test_random_traffic(input int count);
        int               roll;
        logic [ACT_W-1:0] act;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                act = ACT_ALLOC;
            else if (roll < 50)
                act = ACT_SET;
            else if (roll < 68)
                act = ACT_QUERY;
            else if (roll < 85)
                act = ACT_RELEASE;
            else if (roll < 95)
                act = ACT_TICK;
            else
                act = ACT_TICK + ACT_W'($urandom_range(1, 3));
            send_req(act, pick_txn_id(), TAG_W'($urandom), TAG_W'($urandom));
        end
    endtask

    // Result side stalls in bursts
    always @(posedge clk)
    begin
        if (!rst_n || !idle_on)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
                report_mismatch($sformatf("unexpected result: status %0d id %0d",
                                          status, result_id));
            else
            begin
                head_reply = replies_due.pop_front();
                if (status !== head_reply.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, head_reply.status));
                if (result_id !== head_reply.id)
                    report_mismatch($sformatf("result_id %0d, expected %0d",
                                              result_id, head_reply.id));
                if (subject_out !== head_reply.subj)
                    report_mismatch($sformatf("subject_out %h, expected %h",
                                              subject_out, head_reply.subj));
                if (requester_out !== head_reply.req)
                    report_mismatch($sformatf("requester_out %h, expected %h",
                                              requester_out, head_reply.req));
                if (last !== head_reply.last)
                    report_mismatch($sformatf("last %0d, expected %0d",
                                              last, head_reply.last));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("transaction_id_allocator_timeout_core test failed");
        $finish;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = '0;
        txn_id       = '0;
        subject_in   = '0;
        requester_in = '0;
        mismatches   = 0;
        idle_on      = 1'b1;
        for (int i = 0; i < NUM_IDS; i++)
        begin
            live[i]     = 1'b0;
            stale[i]    = 1'b0;
            subj_tag[i] = '0;
            req_tag[i]  = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_full_table();
        test_tag_extremes();
        test_bad_ids();
        test_two_tick_expiry();
        test_random_traffic(225);
        idle_on = 1'b0;
        test_random_traffic(80);

        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("transaction_id_allocator_timeout_core test passed");
        else
            $display("transaction_id_allocator_timeout_core test failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/tida_pkg.sv
hw/rtl/tida_cell.sv
hw/rtl/transaction_id_allocator_timeout_core.sv
sim/transaction_id_allocator_timeout_core_tb.sv
